>>> src/tamd_pkg.sv
package tamd_pkg;

	localparam int SAMPLE_W = 16;
	localparam int CFG_W = 7;
	localparam int DEFAULT_LEN = 8;
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] rate_x;
		logic signed [SAMPLE_W-1:0] rate_y;
		logic signed [SAMPLE_W-1:0] rate_z;
	} rate_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] out_x;
		logic signed [SAMPLE_W-1:0] out_y;
		logic signed [SAMPLE_W-1:0] out_z;
	} result_t;

	typedef struct packed {
		logic busy;
		logic done;
	} lane_stat_t;

endpackage

>>> src/tamd_lane.sv
module tamd_lane #(
	parameter int SUM_W = 22
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    clear,
	input  logic                                    accept,
	input  logic                                    last,
	input  logic signed [tamd_pkg::SAMPLE_W-1:0]    sample,
	output logic signed [SUM_W-1:0]                 fin_sum_s1,
	output logic signed [tamd_pkg::SAMPLE_W-1:0]    fin_min_s1,
	output logic signed [tamd_pkg::SAMPLE_W-1:0]    fin_max_s1
);

	logic signed [SUM_W-1:0]              sum_q;
	logic signed [tamd_pkg::SAMPLE_W-1:0] min_q;
	logic signed [tamd_pkg::SAMPLE_W-1:0] max_q;
	logic signed [SUM_W-1:0]              sum_nxt;
	logic signed [tamd_pkg::SAMPLE_W-1:0] min_nxt;
	logic signed [tamd_pkg::SAMPLE_W-1:0] max_nxt;

	always_comb begin
		sum_nxt = sum_q + SUM_W'(sample);
		min_nxt = (sample < min_q) ? sample : min_q;
		max_nxt = (sample > max_q) ? sample : max_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			min_q <= tamd_pkg::SAMPLE_MAX;
			max_q <= tamd_pkg::SAMPLE_MIN;
		end else if (clear || (accept && last)) begin
			sum_q <= '0;
			min_q <= tamd_pkg::SAMPLE_MAX;
			max_q <= tamd_pkg::SAMPLE_MIN;
		end else if (accept) begin
			sum_q <= sum_nxt;
			min_q <= min_nxt;
			max_q <= max_nxt;
		end
	end

	// window snapshot for the divider
	always_ff @(posedge clk) begin
		if (accept && last) begin
			fin_sum_s1 <= sum_nxt;
			fin_min_s1 <= min_nxt;
			fin_max_s1 <= max_nxt;
		end
	end

endmodule

>>> src/tamd_div.sv
module tamd_div #(
	parameter int SUM_W = 22,
	parameter int LEN_W = 7
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    start,
	input  logic [LEN_W-1:0]                        len,
	input  logic signed [SUM_W-1:0]                 fin_sum,
	input  logic signed [tamd_pkg::SAMPLE_W-1:0]    fin_min,
	input  logic signed [tamd_pkg::SAMPLE_W-1:0]    fin_max,
	input  logic                                    take,
	output tamd_pkg::lane_stat_t                    stat,
	output logic signed [tamd_pkg::SAMPLE_W-1:0]    mean
);

	localparam int CNT_W = $clog2(SUM_W);

	typedef enum logic [2:0] {
		IDLE,
		TRIM,
		MAG,
		RUN,
		FIX,
		DONE
	} state_t;

	state_t             state_q;
	logic [LEN_W-1:0]   div_q;
	logic               trim_q;
	logic               neg_q;
	logic signed [SUM_W-1:0] num_q;
	logic [SUM_W-1:0]   quo_q;
	logic [LEN_W-1:0]   rem_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [LEN_W:0]     part;
	logic [LEN_W:0]     diff;
	logic               fits;

	always_comb begin
		part = {rem_q, quo_q[SUM_W-1]};
		diff = part - {1'b0, div_q};
		fits = part >= {1'b0, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			cnt_q   <= '0;
			div_q   <= '0;
			trim_q  <= 1'b0;
			neg_q   <= 1'b0;
			num_q   <= '0;
			quo_q   <= '0;
			rem_q   <= '0;
		end else begin
			case (state_q)
				IDLE: begin
					if (start) begin
						trim_q <= len > LEN_W'(2);
						if (len > LEN_W'(2)) begin
							div_q <= len - LEN_W'(2);
						end else begin
							div_q <= len;
						end
						state_q <= TRIM;
					end
				end
				TRIM: begin
					if (trim_q) begin
						num_q <= fin_sum - SUM_W'(fin_min) - SUM_W'(fin_max);
					end else begin
						num_q <= fin_sum;
					end
					state_q <= MAG;
				end
				MAG: begin
					neg_q   <= num_q[SUM_W-1];
					quo_q   <= num_q[SUM_W-1] ? SUM_W'(-num_q) : SUM_W'(num_q);
					rem_q   <= '0;
					cnt_q   <= '0;
					state_q <= RUN;
				end
				RUN: begin
					rem_q <= fits ? diff[LEN_W-1:0] : part[LEN_W-1:0];
					quo_q <= {quo_q[SUM_W-2:0], fits};
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(SUM_W - 1)) begin
						state_q <= FIX;
					end
				end
				FIX: begin
					if (neg_q) begin
						quo_q <= -quo_q;
					end
					state_q <= DONE;
				end
				DONE: begin
					if (take) begin
						state_q <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	assign stat.busy = state_q != IDLE;
	assign stat.done = state_q == DONE;
	assign mean      = quo_q[tamd_pkg::SAMPLE_W-1:0];

endmodule

>>> src/tamd_merge.sv
module tamd_merge (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    done,
	input  logic signed [tamd_pkg::SAMPLE_W-1:0]    mean_x,
	input  logic signed [tamd_pkg::SAMPLE_W-1:0]    mean_y,
	input  logic signed [tamd_pkg::SAMPLE_W-1:0]    mean_z,
	output logic                                    take,
	output logic                                    result_valid,
	input  logic                                    result_ready,
	output tamd_pkg::result_t                       result
);

	logic                                 valid_q;
	tamd_pkg::result_t                    result_q;
	logic signed [tamd_pkg::SAMPLE_W-1:0] neg_x;

	assign neg_x = (mean_x == tamd_pkg::SAMPLE_MIN) ? tamd_pkg::SAMPLE_MAX : -mean_x;
	assign take  = done && (!valid_q || result_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= 1'b1;
		end else if (result_ready) begin
			valid_q <= 1'b0;
		end
	end

	// axis remap onto the board frame
	always_ff @(posedge clk) begin
		if (take) begin
			result_q.out_x <= mean_y;
			result_q.out_y <= neg_x;
			result_q.out_z <= mean_z;
		end
	end

	assign result_valid = valid_q;
	assign result       = result_q;

endmodule

>>> src/three_axis_trimmed_mean_decimator.sv
// three-axis trimmed-mean decimator
// sample channel (sample_valid/sample_ready/sample) takes one x/y/z rate transaction a cycle;
// every window_length samples one result transaction leaves on result_valid/result_ready.
// per axis the result is the window mean with the smallest and largest sample dropped
// (length 1 passes the sample, length 2 averages two), truncated toward zero;
// out_x carries y, out_y the negated x mean saturated to 32767, out_z carries z.
// cfg_valid/cfg_ready writes window_length (0 acts as 1, above MAX_WINDOW as MAX_WINDOW)
// and restarts the current window; cfg_ready is always high.
// from the last sample of a window, each axis passes the lane snapshot register, the
// bit-serial divider (TRIM, MAG, RUN over SUM_W = 16 + clog2(MAX_WINDOW) bits, FIX,
// DONE) and the merge output register to result_valid. samples are taken one a cycle;
// the sample that closes a window waits while the previous window is still in the
// divider, so a window cannot close before the previous result has left the divider.
// a finished result sits in the output register; while the receiver stalls the next
// window still collects and its division completes, then waits for the register.
// reset clears the window, sets window_length to min(8, MAX_WINDOW), drops a pending result.
module three_axis_trimmed_mean_decimator #(
	parameter int MAX_WINDOW = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          sample_valid,
	output logic                          sample_ready,
	input  tamd_pkg::rate_t               sample,
	output logic                          result_valid,
	input  logic                          result_ready,
	output tamd_pkg::result_t             result,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [tamd_pkg::CFG_W-1:0]    window_length
);

	localparam int LEN_W = $clog2(MAX_WINDOW + 1);
	localparam int SUM_W = tamd_pkg::SAMPLE_W + $clog2(MAX_WINDOW);
	localparam int CMP_W = ((LEN_W > tamd_pkg::CFG_W) ? LEN_W : tamd_pkg::CFG_W) + 1;
	localparam int RESET_LEN = (MAX_WINDOW < tamd_pkg::DEFAULT_LEN) ? MAX_WINDOW :
		tamd_pkg::DEFAULT_LEN;

	logic [LEN_W-1:0]  len_q;
	logic [LEN_W-1:0]  count_q;
	logic [LEN_W-1:0]  count_nxt;
	logic [LEN_W-1:0]  len_new;
	logic [CMP_W-1:0]  wl_ext;
	logic              last;
	logic              accept;
	logic              cfg_write;
	logic              take;
	logic              back_busy;
	logic              back_done;

	logic signed [tamd_pkg::SAMPLE_W-1:0] samp     [3];
	logic signed [SUM_W-1:0]              fin_sum  [3];
	logic signed [tamd_pkg::SAMPLE_W-1:0] fin_min  [3];
	logic signed [tamd_pkg::SAMPLE_W-1:0] fin_max  [3];
	logic signed [tamd_pkg::SAMPLE_W-1:0] mean     [3];
	tamd_pkg::lane_stat_t                 stat     [3];

	assign samp[0] = sample.rate_x;
	assign samp[1] = sample.rate_y;
	assign samp[2] = sample.rate_z;

	always_comb begin
		wl_ext = CMP_W'(window_length);
		if (wl_ext == '0) begin
			len_new = LEN_W'(1);
		end else if (wl_ext > CMP_W'(MAX_WINDOW)) begin
			len_new = LEN_W'(MAX_WINDOW);
		end else begin
			len_new = wl_ext[LEN_W-1:0];
		end
	end

	assign back_busy    = stat[0].busy | stat[1].busy | stat[2].busy;
	assign back_done    = stat[0].done & stat[1].done & stat[2].done;
	assign count_nxt    = count_q + LEN_W'(1);
	assign last         = count_nxt == len_q;
	assign cfg_ready    = 1'b1;
	assign cfg_write    = cfg_valid && cfg_ready;
	assign sample_ready = !(last && back_busy);
	assign accept       = sample_valid && sample_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= LEN_W'(RESET_LEN);
			count_q <= '0;
		end else if (cfg_write) begin
			len_q   <= len_new;
			count_q <= '0;
		end else if (accept) begin
			count_q <= last ? '0 : count_nxt;
		end
	end

	for (genvar a = 0; a < 3; a++) begin : g_axis
		tamd_lane #(
			.SUM_W(SUM_W)
		) u_lane (
			.clk        (clk),
			.arst_n     (arst_n),
			.clear      (cfg_write),
			.accept     (accept),
			.last       (last),
			.sample     (samp[a]),
			.fin_sum_s1 (fin_sum[a]),
			.fin_min_s1 (fin_min[a]),
			.fin_max_s1 (fin_max[a])
		);

		tamd_div #(
			.SUM_W(SUM_W),
			.LEN_W(LEN_W)
		) u_div (
			.clk     (clk),
			.arst_n  (arst_n),
			.start   (accept && last),
			.len     (len_q),
			.fin_sum (fin_sum[a]),
			.fin_min (fin_min[a]),
			.fin_max (fin_max[a]),
			.take    (take),
			.stat    (stat[a]),
			.mean    (mean[a])
		);
	end

	tamd_merge u_merge (
		.clk          (clk),
		.arst_n       (arst_n),
		.done         (back_done),
		.mean_x       (mean[0]),
		.mean_y       (mean[1]),
		.mean_z       (mean[2]),
		.take         (take),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule
